[rtl/gha_pkg.sv]
// ----------------------------------------------------------------------------
// gha_pkg: shared types and codes of the handle allocator
// status codes, request modes, field widths and the stack control bundle
// ----------------------------------------------------------------------------
package gha_pkg;

    localparam int GEN_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 5;
    localparam int HSLOT_W    = 8;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_INVALID = 2'd2;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // one free-stack operation per cycle at most
    typedef struct packed {
        logic pop;
        logic push;
    } t_stack_op;

endpackage

[rtl/generational_handle_allocator_top.sv]
// ----------------------------------------------------------------------------
// generational_handle_allocator_top: generational slot handle allocator
// allocates and releases slot handles (slot plus 16-bit generation)
// ----------------------------------------------------------------------------
// usage
//   request channel: i_valid / o_stall with i_mode, i_handle_slot and
//   i_handle_generation; a transfer happens on a rising edge with i_valid
//   high and o_stall low
//   result channel: o_valid / i_stall with o_status, o_slot_out and
//   o_generation_out; exactly one result per request, in request order
//   a request taken waits in the request stage; its result is registered
//   once the result register is free, and stays on the ports from then on
//   throughput: one request per cycle while results are not stalled, set by the
//   single request stage, which does stack pop/push and generation update
//   the generation table is read at request transfer (one registered port),
//   the free stack keeps the entry below its top prefetched
//   reset (synchronous, active low): all slots free, stack top is the
//   highest slot, generations zero, no slot live, both channels empty
//   stall: while i_stall holds a result, one more request can sit in the
//   request stage; after that o_stall rises until the result moves on
// ----------------------------------------------------------------------------
module generational_handle_allocator_top import gha_pkg::*; #(
    parameter int SLOTS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_mode,
    input  logic [HSLOT_W-1:0]    i_handle_slot,
    input  logic [GEN_W-1:0]      i_handle_generation,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic [SLOT_OUT_W-1:0] o_slot_out,
    output logic [GEN_W-1:0]      o_generation_out
);

    localparam int SW = $clog2(SLOTS);

    // request stage
    logic             r_v;
    logic             r_mode;
    logic [SW-1:0]    r_slot;
    logic             r_in_range;
    logic [GEN_W-1:0] r_hgen;

    // generation table and its read port
    logic [GEN_W-1:0] r_gen_mem [SLOTS];
    logic [GEN_W-1:0] r_gen_rd;
    logic             r_gen_fwd;
    logic [GEN_W-1:0] r_gen_fwd_data;
    logic [SLOTS-1:0] r_live;

    // result register
    logic             r_ov;
    t_status          r_status;
    logic [SLOT_OUT_W-1:0] r_slot_out;
    logic [GEN_W-1:0] r_gen_out;

    logic             accept;
    logic             adv;
    logic [SW-1:0]    rd_idx;
    logic [GEN_W-1:0] cur_gen;
    logic             gen_we;
    logic [SW-1:0]    gen_waddr;
    logic [GEN_W-1:0] gen_wdata;
    t_status          n_status;
    logic [SLOT_OUT_W-1:0] n_slot_out;
    logic [GEN_W-1:0] n_gen_out;

    t_stack_op        stack_op;
    logic [SW-1:0]    top_slot;
    logic [GEN_W-1:0] top_gen;
    logic             stack_empty;

    // handshake: the request stage moves on whenever the result register
    // is empty or its result is being taken
    assign adv     = r_v && (!r_ov || !i_stall);
    assign o_stall = r_v && !adv;
    assign accept  = i_valid && !o_stall;
    assign rd_idx  = i_handle_slot[SW-1:0];

    assign o_valid          = r_ov;
    assign o_status         = r_status;
    assign o_slot_out       = r_slot_out;
    assign o_generation_out = r_gen_out;

    // generation read at transfer, with the write of the same edge forwarded
    assign cur_gen = r_gen_fwd ? r_gen_fwd_data : r_gen_rd;

    gha_free_stack #(
        .SLOTS (SLOTS)
    ) u_free_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (stack_op),
        .i_push_slot (r_slot),
        .i_push_gen  (r_hgen),
        .o_top_slot  (top_slot),
        .o_top_gen   (top_gen),
        .o_empty     (stack_empty)
    );

    // request evaluation; a free slot carries its generation on the stack,
    // so an allocate never has to read the generation table
    always_comb begin
        stack_op   = '0;
        gen_we     = 1'b0;
        gen_waddr  = top_slot;
        gen_wdata  = top_gen + GEN_W'(1);
        n_status   = ST_OK;
        n_slot_out = '0;
        n_gen_out  = '0;
        if (r_mode == MODE_ALLOC) begin
            if (stack_empty) begin
                n_status = ST_FULL;
            end else begin
                n_slot_out   = SLOT_OUT_W'(top_slot);
                n_gen_out    = gen_wdata;
                stack_op.pop = adv;
                gen_we       = adv;
            end
        end else begin
            if (!r_in_range) begin
                n_status = ST_INVALID;
            end else if (!r_live[r_slot] || (cur_gen != r_hgen)) begin
                // stale handle, double release or never allocated
                n_status = ST_INVALID;
            end else begin
                stack_op.push = adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= 1'b0;
            r_ov   <= 1'b0;
            r_live <= '0;
        end else begin
            if (accept) begin
                r_v <= 1'b1;
            end else if (adv) begin
                r_v <= 1'b0;
            end
            if (adv) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (gen_we) begin
                r_live[gen_waddr] <= 1'b1;
            end
            if (stack_op.push) begin
                r_live[r_slot] <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode         <= i_mode;
            r_slot         <= rd_idx;
            r_in_range     <= ({1'b0, i_handle_slot} < (HSLOT_W + 1)'(SLOTS));
            r_hgen         <= i_handle_generation;
            r_gen_fwd      <= gen_we && (gen_waddr == rd_idx);
            r_gen_fwd_data <= gen_wdata;
        end
        if (adv) begin
            r_status   <= n_status;
            r_slot_out <= n_slot_out;
            r_gen_out  <= n_gen_out;
        end
    end

    // generation table, read-first, registered read
    always_ff @(posedge i_clk) begin
        if (gen_we) begin
            r_gen_mem[gen_waddr] <= gen_wdata;
        end
        if (accept) begin
            r_gen_rd <= r_gen_mem[rd_idx];
        end
    end

endmodule

[rtl/gha_free_stack.sv]
// ----------------------------------------------------------------------------
// gha_free_stack: free-slot stack
// top entry held in registers, lower entries in a memory with one
// registered read port that always prefetches the entry below the top
// ----------------------------------------------------------------------------
module gha_free_stack import gha_pkg::*; #(
    parameter int SLOTS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_stack_op                i_op,
    input  logic [$clog2(SLOTS)-1:0] i_push_slot,
    input  logic [GEN_W-1:0]         i_push_gen,
    output logic [$clog2(SLOTS)-1:0] o_top_slot,
    output logic [GEN_W-1:0]         o_top_gen,
    output logic                     o_empty
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = SW + GEN_W;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [SW-1:0]    r_top_slot;
    logic [SW-1:0]    n_top_slot;
    logic [GEN_W-1:0] r_top_gen;
    logic [GEN_W-1:0] n_top_gen;

    logic [EW-1:0]    r_mem [SLOTS];
    logic [EW-1:0]    r_mem_rd;
    logic [SLOTS-1:0] r_filled;

    logic             r_sec_fwd;
    logic             r_sec_filled;
    logic [SW-1:0]    r_sec_addr;
    logic [EW-1:0]    r_sec_wdata;

    logic             we;
    logic [SW-1:0]    waddr;
    logic [EW-1:0]    wdata;
    logic [SW-1:0]    rd_addr;
    logic [EW-1:0]    second;

    assign o_top_slot = r_top_slot;
    assign o_top_gen  = r_top_gen;
    assign o_empty    = (r_count == '0);

    // entry below the top; a never-written entry reads as its own slot, generation zero
    always_comb begin
        if (r_sec_fwd) begin
            second = r_sec_wdata;
        end else if (r_sec_filled) begin
            second = r_mem_rd;
        end else begin
            second = {r_sec_addr, GEN_W'(0)};
        end
    end

    always_comb begin
        n_count    = r_count;
        n_top_slot = r_top_slot;
        n_top_gen  = r_top_gen;
        we         = 1'b0;
        waddr      = SW'(r_count - CW'(1));
        wdata      = {r_top_slot, r_top_gen};
        if (i_op.pop) begin
            n_count    = r_count - CW'(1);
            n_top_slot = second[EW-1:GEN_W];
            n_top_gen  = second[GEN_W-1:0];
        end else if (i_op.push) begin
            n_count    = r_count + CW'(1);
            n_top_slot = i_push_slot;
            n_top_gen  = i_push_gen;
            // old top moves down into the memory
            we         = (r_count != '0);
        end
        rd_addr = (n_count >= CW'(2)) ? SW'(n_count - CW'(2)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= CW'(SLOTS);
            r_top_slot   <= SW'(SLOTS - 1);
            r_top_gen    <= '0;
            r_filled     <= '0;
            r_sec_fwd    <= 1'b0;
            r_sec_filled <= 1'b0;
            r_sec_addr   <= SW'(SLOTS - 2);
        end else begin
            r_count      <= n_count;
            r_top_slot   <= n_top_slot;
            r_top_gen    <= n_top_gen;
            if (we) begin
                r_filled[waddr] <= 1'b1;
            end
            r_sec_fwd    <= we && (waddr == rd_addr);
            r_sec_filled <= r_filled[rd_addr];
            r_sec_addr   <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sec_wdata <= wdata;
    end

    // stack memory, read-first, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_mem_rd <= r_mem[rd_addr];
    end

endmodule

[dv/tb_generational_handle_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_generational_handle_allocator_top: handle allocator testbench
// drives allocate and release requests over the valid/stall request channel,
// predicts each status, slot and generation from a local model of the free
// stack, generation table and live bits, and checks every result transfer
// in order while both sides idle and stall at random
// ----------------------------------------------------------------------------
module tb_generational_handle_allocator_top;
    import gha_pkg::*;

    localparam int POOL        = 32;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 210;

    // one request as offered on the request channel
    typedef struct packed {
        logic               mode;
        logic [HSLOT_W-1:0] slot;
        logic [GEN_W-1:0]   gen;
    } t_request;

    // one result as seen on the result channel
    typedef struct packed {
        t_status               status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [GEN_W-1:0]      gen;
    } t_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_mode = MODE_ALLOC;
    logic [HSLOT_W-1:0]    i_handle_slot = '0;
    logic [GEN_W-1:0]      i_handle_generation = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [SLOT_OUT_W-1:0] o_slot_out;
    logic [GEN_W-1:0]      o_generation_out;

    generational_handle_allocator_top #(
        .SLOTS(POOL)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_mode             (i_mode),
        .i_handle_slot      (i_handle_slot),
        .i_handle_generation(i_handle_generation),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_slot_out         (o_slot_out),
        .o_generation_out   (o_generation_out)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // allocator state as the testbench sees it
    // ------------------------------------------------------------------
    logic [SLOT_OUT_W-1:0] free_slots [POOL];
    int                    free_depth;
    logic [GEN_W-1:0]      gen_of [POOL];
    logic                  live [POOL];

    t_request requests_to_send [$];
    t_outcome outcomes_due [$];

    int  requests_queued   = 0;
    int  requests_accepted = 0;
    int  error_count       = 0;
    int  cycle_count       = 0;
    int  send_idle_pct     = 0;
    int  stall_pct         = 0;
    int  hold_left         = 0;
    bit  hold_start        = 1'b0;
    bit  req_taken         = 1'b0;

    // applies one request to the local allocator state, returns its result
    function automatic t_outcome apply_request(logic mode, logic [HSLOT_W-1:0] hslot,
                                               logic [GEN_W-1:0] hgen);
        t_outcome              res;
        logic [SLOT_OUT_W-1:0] s;
        res        = '0;
        res.status = ST_OK;
        if (mode == MODE_ALLOC) begin
            if (free_depth == 0) begin
                // pool exhausted, nothing changes
                res.status = ST_FULL;
            end else begin
                free_depth--;
                s         = free_slots[free_depth];
                gen_of[s] = gen_of[s] + 1'b1;   // wraps at 16 bits
                live[s]   = 1'b1;
                res.slot  = s;
                res.gen   = gen_of[s];
            end
        end else if (hslot >= POOL || gen_of[hslot] != hgen || !live[hslot]
                     || free_depth >= POOL) begin
            // out of range, stale generation or slot not live
            res.status = ST_INVALID;
        end else begin
            live[hslot]            = 1'b0;
            free_slots[free_depth] = hslot[SLOT_OUT_W-1:0];
            free_depth++;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic queue_request(logic mode, int unsigned slot, int unsigned gen);
        t_request r;
        r.mode = mode;
        r.slot = HSLOT_W'(slot);
        r.gen  = GEN_W'(gen);
        requests_to_send.push_back(r);
        requests_queued++;
    endtask

    // sender holds off until every queued request is taken and every result is in
    task automatic wait_until_drained();
        do @(negedge i_clk);
        while (requests_accepted != requests_queued || outcomes_due.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic release_every_live();
        for (int s = 0; s < POOL; s++)
            if (live[s])
                queue_request(MODE_RELEASE, s, gen_of[s]);
    endtask

    // mixed batch planned from the allocator state once the pipe is empty:
    // allocates, good releases of live handles, double releases, stale
    // generations and random handles anywhere in the slot field
    task automatic plan_mixed_batch(int n, int alloc_pct);
        int live_pool [$];
        int freed [$];
        int idx;
        int s;
        int kind;
        for (int i = 0; i < POOL; i++)
            if (live[i])
                live_pool.push_back(i);
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 99) < alloc_pct) begin
                // allocate ignores the handle fields, so fill them with noise
                queue_request(MODE_ALLOC, $urandom_range(0, 255), $urandom_range(0, 65535));
            end else if (kind < 6 && live_pool.size() != 0) begin
                idx = $urandom_range(0, live_pool.size() - 1);
                s   = live_pool[idx];
                live_pool.delete(idx);
                freed.push_back(s);
                queue_request(MODE_RELEASE, s, gen_of[s]);
            end else if (kind == 6 && freed.size() != 0) begin
                s = freed[$urandom_range(0, freed.size() - 1)];
                queue_request(MODE_RELEASE, s, gen_of[s]);
            end else if (kind == 7) begin
                s = $urandom_range(0, POOL - 1);
                queue_request(MODE_RELEASE, s, gen_of[s] + $urandom_range(1, 65535));
            end else begin
                queue_request(MODE_RELEASE, $urandom_range(0, 255), $urandom_range(0, 65535));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // request driver: a new transfer is offered only once the previous one
    // has gone, so valid never reacts to stall and a held payload stays put
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_requests
        t_request item;
        if (i_rst_n && (!i_valid || req_taken)) begin
            if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                item                 = requests_to_send.pop_front();
                i_valid             <= 1'b1;
                i_mode              <= item.mode;
                i_handle_slot       <= item.slot;
                i_handle_generation <= item.gen;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure, with a long hold-off on demand
    always @(negedge i_clk) begin : drive_stall
        if (hold_start) begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: result transfers are checked before the request transfer of
    // the same edge is predicted, since a result never belongs to a request
    // taken at that same edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_channels
        t_outcome want;
        req_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (outcomes_due.size() == 0) begin
                    report_mismatch("result transfer with no request outstanding");
                end else begin
                    want = outcomes_due.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, want.status));
                    if (o_slot_out !== want.slot)
                        report_mismatch($sformatf("slot %0d, expected %0d",
                                                  o_slot_out, want.slot));
                    if (o_generation_out !== want.gen)
                        report_mismatch($sformatf("generation %0d, expected %0d",
                                                  o_generation_out, want.gen));
                end
            end
            if (i_valid && !o_stall) begin
                outcomes_due.push_back(apply_request(i_mode, i_handle_slot,
                                                     i_handle_generation));
                requests_accepted++;
            end
        end
    end

    // run-away guard
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        int idle_plan [4];
        int stall_plan [4];
        int pick [3];
        int laps;
        idle_plan  = '{0, 69, 0, 15};
        stall_plan = '{0, 0, 69, 15};
        pick       = '{15, 50, 85};

        // all slots free with the highest on top, generations zero, none live
        for (int i = 0; i < POOL; i++) begin
            free_slots[i] = SLOT_OUT_W'(i);
            gen_of[i]     = '0;
            live[i]       = 1'b0;
        end
        free_depth = POOL;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, back to back
        queue_request(MODE_RELEASE, 0, 0);              // generation matches, never allocated
        queue_request(MODE_RELEASE, 255, 16'hFFFF);     // far beyond the pool
        queue_request(MODE_RELEASE, POOL, 1);           // first slot past the pool
        queue_request(MODE_RELEASE, POOL - 1, 16'hFFFF);
        queue_request(MODE_ALLOC, 0, 0);                // top of stack, generation 1
        queue_request(MODE_ALLOC, 255, 16'hFFFF);       // handle fields ignored
        queue_request(MODE_RELEASE, POOL - 1, 2);       // generation ahead
        queue_request(MODE_RELEASE, POOL - 1, 0);       // generation behind
        queue_request(MODE_RELEASE, POOL - 1, 1);       // good release
        queue_request(MODE_RELEASE, POOL - 1, 1);       // double release
        queue_request(MODE_ALLOC, 0, 0);                // same slot comes back, generation 2
        queue_request(MODE_RELEASE, POOL - 2, 1);
        queue_request(MODE_RELEASE, POOL - 1, 2);
        queue_request(MODE_ALLOC, 0, 0);
        queue_request(MODE_ALLOC, 0, 0);
        queue_request(MODE_RELEASE, 0, 0);
        wait_until_drained();

        // run the pool dry and past it, then give everything back plus one twice
        repeat (free_depth + 3)
            queue_request(MODE_ALLOC, $urandom_range(0, 255), $urandom_range(0, 65535));
        wait_until_drained();
        release_every_live();
        queue_request(MODE_RELEASE, 0, gen_of[0]);
        wait_until_drained();

        // random batches under each idling pattern
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_plan[ph];
            stall_pct     = stall_plan[ph];
            laps          = requests_queued + PHASE_ITEMS;
            while (requests_queued < laps) begin
                plan_mixed_batch($urandom_range(8, 40), pick[$urandom_range(0, 2)]);
                wait_until_drained();
            end
        end

        // long receiver hold-off while the sender keeps offering transfers
        send_idle_pct = 0;
        stall_pct     = 0;
        plan_mixed_batch(40, 50);
        hold_start = 1'b1;
        wait_until_drained();

        // quiet tail to catch any stray result transfer
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
